// ===== src/sfb_pkg.sv =====
// ----------------------------------------------------------------------------
// sfb_pkg
// Shared types, framing bytes and the escape function for the frame builder.
// ----------------------------------------------------------------------------
package sfb_pkg;

    localparam logic [7:0] START_BYTE = 8'h3C;  // '<'
    localparam logic [7:0] END_BYTE   = 8'h3E;  // '>'
    localparam logic [7:0] ESC_BYTE   = 8'h3D;  // '='

    localparam int MAX_BYTES = 4;
    localparam int IDX_W     = $clog2(MAX_BYTES);

    // One classified input item: up to four output bytes in send order.
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [IDX_W-1:0]          last_idx;
    } sfb_job_t;

    function automatic logic [7:0] sfb_escape(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b == START_BYTE || b == END_BYTE)
        begin
            r = ESC_BYTE;
        end
        return r;
    endfunction

endpackage

// ===== src/sfb_in_if.sv =====
// ----------------------------------------------------------------------------
// sfb_in_if
// Input channel: one byte with frame start and frame end marks.
// ----------------------------------------------------------------------------
interface sfb_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       starts_frame;
    logic       ends_frame;

    modport source (output valid, output data_byte, output starts_frame,
                    output ends_frame, input ready);
    modport sink   (input valid, input data_byte, input starts_frame,
                    input ends_frame, output ready);
endinterface

// ===== src/sfb_out_if.sv =====
// ----------------------------------------------------------------------------
// sfb_out_if
// Output channel: one byte of the framed serial stream.
// ----------------------------------------------------------------------------
interface sfb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;

    modport source (output valid, output out_byte, output run_last, input ready);
    modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

// ===== src/sfb_front.sv =====
// ----------------------------------------------------------------------------
// sfb_front
// Accepts input items, tracks frame state and checksum, builds byte jobs.
// ----------------------------------------------------------------------------
module sfb_front
    import sfb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    sfb_in_if.sink   in,
    input  logic     q_full,
    output logic     q_push,
    output sfb_job_t q_job
);

    logic [6:0] running_sum_reg, running_sum_next;
    logic       frame_open_reg, frame_open_next;
    logic       accept;
    logic [7:0] esc;
    logic [6:0] sum_new;
    logic [7:0] chk;

    assign in.ready = !q_full;
    assign accept   = in.valid && in.ready;

    always_comb
    begin
        esc     = sfb_escape(in.data_byte);
        sum_new = in.starts_frame ? in.data_byte[6:0] : running_sum_reg + esc[6:0];
        chk     = sfb_escape({1'b0, sum_new});

        if (in.starts_frame)
        begin
            q_job.bytes[0] = START_BYTE;
            q_job.bytes[1] = in.data_byte;
            q_job.bytes[2] = chk;
            q_job.bytes[3] = END_BYTE;
            q_job.last_idx = in.ends_frame ? IDX_W'(3) : IDX_W'(1);
        end
        else
        begin
            q_job.bytes[0] = esc;
            q_job.bytes[1] = chk;
            q_job.bytes[2] = END_BYTE;
            q_job.bytes[3] = END_BYTE;
            q_job.last_idx = in.ends_frame ? IDX_W'(2) : IDX_W'(0);
        end

        // drop payload when no frame is open
        q_push           = accept && (in.starts_frame || frame_open_reg);
        running_sum_next = running_sum_reg;
        frame_open_next  = frame_open_reg;
        if (q_push)
        begin
            running_sum_next = sum_new;
            frame_open_next  = !in.ends_frame;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_sum_reg <= '0;
            frame_open_reg  <= 1'b0;
        end
        else
        begin
            running_sum_reg <= running_sum_next;
            frame_open_reg  <= frame_open_next;
        end
    end

    a_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && in.ends_frame) |=> !frame_open_reg)
        else $error("frame still open after end item");

endmodule

// ===== src/sfb_queue.sv =====
// ----------------------------------------------------------------------------
// sfb_queue
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module sfb_queue
    import sfb_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  sfb_job_t push_job,
    output logic     full,
    input  logic     pop,
    output logic     head_valid,
    output sfb_job_t head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sfb_job_t         store [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = store[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue pop while empty");

endmodule

// ===== src/sfb_back.sv =====
// ----------------------------------------------------------------------------
// sfb_back
// Serializes queued jobs to the output, one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
module sfb_back
    import sfb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head_valid,
    input  sfb_job_t  head_job,
    output logic      pop,
    sfb_out_if.source out
);

    sfb_job_t         job_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             busy_reg;
    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic             run_last_reg;

    logic             advance;
    logic             have;
    sfb_job_t         cur_job;
    logic [IDX_W-1:0] cur_idx;
    logic             cur_last;

    assign out.valid    = out_valid_reg;
    assign out.out_byte = out_byte_reg;
    assign out.run_last = run_last_reg;

    always_comb
    begin
        advance  = !out_valid_reg || out.ready;
        // take from the running job, else straight from the queue head
        cur_job  = busy_reg ? job_reg : head_job;
        cur_idx  = busy_reg ? idx_reg : '0;
        have     = busy_reg || head_valid;
        cur_last = (cur_idx == cur_job.last_idx);
        pop      = advance && !busy_reg && head_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && have)
        begin
            out_byte_reg <= cur_job.bytes[cur_idx];
            run_last_reg <= cur_last;
            job_reg      <= cur_job;
            idx_reg      <= cur_idx + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= have;
            busy_reg      <= have && !cur_last;
        end
    end

    a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (idx_reg <= job_reg.last_idx && idx_reg != '0))
        else $error("byte index beyond job length");

endmodule

// ===== src/serial_frame_builder.sv =====
// ----------------------------------------------------------------------------
// serial_frame_builder
// Byte framing with escape and 7-bit additive checksum.
// ----------------------------------------------------------------------------
// Usage: items enter on the 'in' channel (data_byte, starts_frame,
// ends_frame); framed bytes leave on the 'out' channel (out_byte, run_last),
// both valid/ready, a transaction completing when both are high.
// A start item yields '<' and the opcode; a payload item yields its escaped
// byte; an end mark adds the escaped checksum and '>'. run_last flags the
// final byte of each item. Payload outside a frame is accepted and dropped.
// The first byte of an item passes through the job queue and the output
// byte register before it is valid on the output.
// Throughput: the output emits one byte per cycle while the receiver is
// ready; an item yields 1 to 4 bytes; the back serializer sets this rate.
// Plain payload items sustain one item per cycle while the receiver is ready.
// A queue of QUEUE_DEPTH jobs sits between front and back; when the receiver
// stalls, the output byte holds and input ready drops once the queue fills.
// Reset clears the checksum, closes any frame and empties the queue.
// ----------------------------------------------------------------------------
module serial_frame_builder
    import sfb_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic      clk,
    input  logic      rst_n,
    sfb_in_if.sink    in,
    sfb_out_if.source out
);

    logic     q_push;
    logic     q_full;
    logic     q_pop;
    logic     q_head_valid;
    sfb_job_t q_push_job;
    sfb_job_t q_head_job;

    sfb_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .in     (in),
        .q_full (q_full),
        .q_push (q_push),
        .q_job  (q_push_job)
    );

    sfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_job   (q_push_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_job   (q_head_job)
    );

    sfb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_job   (q_head_job),
        .pop        (q_pop),
        .out        (out)
    );

endmodule

// ===== tb/serial_frame_builder_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// serial_frame_builder_test
// Drives opcode and payload bytes into the frame builder and checks every
// framed output byte against an in-bench model of the framing, escaping and
// 7-bit checksum. Directed frames cover the marker bytes, empty frames,
// abandoned frames and stray payload; random frames follow under bursty input
// and a receiver that stalls, including one long hold-off.
// ----------------------------------------------------------------------------
module serial_frame_builder_test;
    import sfb_pkg::*;

    localparam int RANDOM_ITEMS = 100;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 100000;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       starts_frame;
        logic       ends_frame;
    } frame_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } framed_byte_t;

    typedef enum logic [1:0] {
        RX_STEADY,
        RX_RANDOM,
        RX_TOGGLE,
        RX_LONG_HOLD
    } rx_mode_t;

    logic clk;
    logic rst_n;

    sfb_in_if  in_if();
    sfb_out_if out_if();

    serial_frame_builder dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (in_if),
        .out   (out_if)
    );

    frame_item_t  pending_items[$];
    framed_byte_t framed_bytes_expected[$];

    // framing state as the block should hold it
    logic [6:0] frame_sum;
    logic       frame_is_open;

    int error_count;
    int bytes_checked;
    int cycle_count;

    // sender pacing
    int burst_left;
    int gap_left;

    // receiver pacing
    rx_mode_t rx_mode;
    int       rx_phase_left;
    int       hold_left;
    logic     long_hold_done;

    always #5 clk = ~clk;

    function automatic logic [7:0] escape_marker(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b == START_BYTE || b == END_BYTE)
        begin
            r = ESC_BYTE;
        end
        return r;
    endfunction

    // Append the framed bytes that one accepted item produces.
    task automatic build_frame_bytes(input frame_item_t it);
        framed_byte_t run[$];
        logic [7:0]   e;
        if (it.starts_frame)
        begin
            run.push_back('{out_byte: START_BYTE, run_last: 1'b0});
            run.push_back('{out_byte: it.data_byte, run_last: 1'b0});
            frame_sum     = it.data_byte[6:0];
            frame_is_open = 1'b1;
        end
        else if (frame_is_open)
        begin
            e = escape_marker(it.data_byte);
            run.push_back('{out_byte: e, run_last: 1'b0});
            frame_sum = frame_sum + e[6:0];
        end
        // drop payload outside a frame, end mark included
        if (run.size() > 0)
        begin
            if (it.ends_frame)
            begin
                run.push_back('{out_byte: escape_marker({1'b0, frame_sum}), run_last: 1'b0});
                run.push_back('{out_byte: END_BYTE, run_last: 1'b0});
                frame_is_open = 1'b0;
            end
            run[run.size() - 1].run_last = 1'b1;
            foreach (run[i])
            begin
                framed_bytes_expected.push_back(run[i]);
            end
        end
    endtask

    task automatic queue_item(input logic [7:0] b, input logic s, input logic e);
        pending_items.push_back('{data_byte: b, starts_frame: s, ends_frame: e});
    endtask

    // Input driver: bursts of random length, random gaps in between.
    always @(posedge clk or negedge rst_n)
    begin
        frame_item_t nxt;
        if (!rst_n)
        begin
            in_if.valid        <= 1'b0;
            in_if.data_byte    <= 8'h00;
            in_if.starts_frame <= 1'b0;
            in_if.ends_frame   <= 1'b0;
            frame_sum     = '0;
            frame_is_open = 1'b0;
            burst_left    = $urandom_range(1, 16);
            gap_left      = 0;
        end
        else
        begin
            if (in_if.valid && in_if.ready)
            begin
                build_frame_bytes('{data_byte: in_if.data_byte,
                                    starts_frame: in_if.starts_frame,
                                    ends_frame: in_if.ends_frame});
            end
            if (!in_if.valid || in_if.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_if.valid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    nxt = pending_items.pop_front();
                    in_if.valid        <= 1'b1;
                    in_if.data_byte    <= nxt.data_byte;
                    in_if.starts_frame <= nxt.starts_frame;
                    in_if.ends_frame   <= nxt.ends_frame;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                                 : $urandom_range(1, 12);
                        gap_left   = $urandom_range(0, 6);
                    end
                end
                else
                begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor and receiver stall pattern.
    always @(posedge clk or negedge rst_n)
    begin
        framed_byte_t want;
        logic         next_ready;
        if (!rst_n)
        begin
            out_if.ready <= 1'b0;
            rx_mode        = RX_STEADY;
            rx_phase_left  = 0;
            hold_left      = 0;
            long_hold_done = 1'b0;
        end
        else
        begin
            if (out_if.valid && out_if.ready)
            begin
                if (framed_bytes_expected.size() == 0)
                begin
                    $error("unexpected output transaction: out_byte=%h run_last=%b",
                           out_if.out_byte, out_if.run_last);
                    error_count++;
                end
                else
                begin
                    want = framed_bytes_expected.pop_front();
                    if (out_if.out_byte !== want.out_byte)
                    begin
                        $error("out_byte: expected %h, actual %h",
                               want.out_byte, out_if.out_byte);
                        error_count++;
                    end
                    if (out_if.run_last !== want.run_last)
                    begin
                        $error("run_last: expected %b, actual %b",
                               want.run_last, out_if.run_last);
                        error_count++;
                    end
                    bytes_checked++;
                end
            end

            if (hold_left > 0)
            begin
                hold_left--;
                next_ready = 1'b0;
            end
            else
            begin
                if (rx_phase_left <= 0)
                begin
                    rx_phase_left = $urandom_range(10, 60);
                    if (!long_hold_done && bytes_checked >= 40)
                    begin
                        rx_mode = RX_LONG_HOLD;
                    end
                    else
                    begin
                        rx_mode = rx_mode_t'($urandom_range(0, 2));
                    end
                end
                rx_phase_left--;
                case (rx_mode)
                    RX_STEADY:    next_ready = 1'b1;
                    RX_RANDOM:    next_ready = ($urandom_range(0, 3) != 0);
                    RX_TOGGLE:    next_ready = rx_phase_left[0];
                    RX_LONG_HOLD:
                    begin
                        // hold off long enough for the job queue and input to back up
                        hold_left      = $urandom_range(80, 120);
                        long_hold_done = 1'b1;
                        rx_mode        = RX_STEADY;
                        next_ready     = 1'b0;
                    end
                    default:      next_ready = 1'b1;
                endcase
            end
            out_if.ready <= next_ready;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL serial_frame_builder");
            $finish;
        end
    end

    initial
    begin
        int         framed_items;
        int         len;
        logic       broken;
        logic       gen_open;
        logic [7:0] op;
        logic [7:0] b;

        clk           = 1'b0;
        rst_n         = 1'b0;
        in_if.valid        = 1'b0;
        in_if.data_byte    = 8'h00;
        in_if.starts_frame = 1'b0;
        in_if.ends_frame   = 1'b0;
        out_if.ready  = 1'b0;
        error_count   = 0;
        bytes_checked = 0;
        cycle_count   = 0;

        // stray payload before any frame, with and without an end mark
        queue_item(8'h41, 1'b0, 1'b0);
        queue_item(START_BYTE, 1'b0, 1'b1);
        // empty frames at the opcode extremes
        queue_item(8'h00, 1'b1, 1'b1);
        queue_item(8'hFF, 1'b1, 1'b1);
        // checksum lands on a marker and must be escaped
        queue_item(START_BYTE, 1'b1, 1'b1);
        queue_item(END_BYTE, 1'b1, 1'b1);
        queue_item(8'hBC, 1'b1, 1'b1);
        // opcode is a marker and passes unescaped; payload markers escape
        queue_item(START_BYTE, 1'b1, 1'b0);
        queue_item(START_BYTE, 1'b0, 1'b0);
        queue_item(END_BYTE, 1'b0, 1'b0);
        queue_item(ESC_BYTE, 1'b0, 1'b0);
        queue_item(8'h00, 1'b0, 1'b0);
        queue_item(8'hFF, 1'b0, 1'b0);
        queue_item(8'h80, 1'b0, 1'b1);
        // abandon an open frame by starting another
        queue_item(8'h10, 1'b1, 1'b0);
        queue_item(8'h20, 1'b0, 1'b0);
        queue_item(8'h05, 1'b1, 1'b0);
        queue_item(8'h7F, 1'b0, 1'b1);
        // payload after close is dropped
        queue_item(8'hAA, 1'b0, 1'b1);
        // checksum wraps past 127
        queue_item(8'h7F, 1'b1, 1'b0);
        queue_item(8'h7F, 1'b0, 1'b0);
        queue_item(8'hF0, 1'b0, 1'b1);

        framed_items = 0;
        gen_open     = 1'b0;
        while (framed_items < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                queue_item(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
                if (gen_open)
                begin
                    framed_items++;
                end
            end
            else
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    // opcode with marker-valued low seven bits: checksum of an empty frame hits the escape
                    op = {1'($urandom_range(0, 1)), 5'b01111, 1'($urandom_range(0, 1)), 1'b0};
                end
                else
                begin
                    op = 8'($urandom_range(0, 255));
                end
                len    = $urandom_range(0, 6);
                broken = ($urandom_range(0, 9) == 0);
                queue_item(op, 1'b1, (len == 0) && !broken);
                framed_items++;
                for (int i = 0; i < len; i++)
                begin
                    if ($urandom_range(0, 5) == 0)
                    begin
                        b = START_BYTE + 8'($urandom_range(0, 2));
                    end
                    else
                    begin
                        b = 8'($urandom_range(0, 255));
                    end
                    queue_item(b, 1'b0, (i == len - 1) && !broken);
                    framed_items++;
                end
                gen_open = broken;
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() > 0 || in_if.valid || framed_bytes_expected.size() > 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && framed_bytes_expected.size() == 0)
        begin
            $display("PASS serial_frame_builder");
        end
        else
        begin
            $display("FAIL serial_frame_builder");
        end
        $finish;
    end

endmodule
